// ----- rtl/core/lcd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_pkg
// Shared types and phase codes for the length/checksum frame deframer.
// ----------------------------------------------------------------------------
package lcd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;
  localparam int unsigned PH_W   = 3;

  localparam logic [PH_W-1:0] PH_IDLE    = 3'd0;
  localparam logic [PH_W-1:0] PH_LEN_HI  = 3'd1;
  localparam logic [PH_W-1:0] PH_LEN_LO  = 3'd2;
  localparam logic [PH_W-1:0] PH_PAYLOAD = 3'd3;
  localparam logic [PH_W-1:0] PH_CHECK   = 3'd4;

  localparam logic [BYTE_W-1:0] SUM_GOOD = 8'hFF;

  typedef struct packed {
    logic              func;
    logic [BYTE_W-1:0] data;
  } lcd_item_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data;
    logic              is_end;
    logic              good;
    logic [LEN_W-1:0]  len;
  } lcd_res_t;

endpackage
`default_nettype wire

// ----- rtl/core/lcd_in_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_in_reg
// Input register: holds one accepted beat until the parser takes it.
// ----------------------------------------------------------------------------
module lcd_in_reg
  import lcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] func
  input  wire logic        advance,
  output logic             item_valid,
  output lcd_item_t        item
);

  logic      valid_r;
  logic      valid_nxt;
  lcd_item_t item_r;

  assign in_tready  = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_tvalid && in_tready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      item_r.func <= in_tuser[0];
      item_r.data <= in_tdata;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/lcd_parse.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_parse
// Frame phase machine: header length, payload count, running checksum.
// ----------------------------------------------------------------------------
module lcd_parse
  import lcd_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      take,
  input  wire lcd_item_t item,
  output lcd_res_t       res
);

  logic [PH_W-1:0]   phase_r,  phase_nxt;
  logic [LEN_W-1:0]  exp_len_r, exp_len_nxt;
  logic [LEN_W-1:0]  taken_r,  taken_nxt;
  logic [BYTE_W-1:0] sum_r,    sum_nxt;
  logic [BYTE_W-1:0] sum_chk;
  logic [LEN_W-1:0]  taken_inc;

  assign sum_chk   = sum_r + item.data;
  assign taken_inc = taken_r + 16'd1;

  always_comb begin
    phase_nxt   = phase_r;
    exp_len_nxt = exp_len_r;
    taken_nxt   = taken_r;
    sum_nxt     = sum_r;
    res         = '0;
    if (item.func) begin
      phase_nxt   = PH_LEN_HI;
      exp_len_nxt = '0;
      taken_nxt   = '0;
      sum_nxt     = '0;
    end else begin
      unique case (phase_r)
        PH_LEN_HI: begin
          exp_len_nxt = {item.data, 8'd0};
          phase_nxt   = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          exp_len_nxt = {exp_len_r[15:8], item.data};
          phase_nxt   = ({exp_len_r[15:8], item.data} == '0) ? PH_CHECK : PH_PAYLOAD;
        end
        PH_PAYLOAD: begin
          sum_nxt   = sum_chk;
          taken_nxt = taken_inc;
          if (taken_inc == exp_len_r) begin
            phase_nxt = PH_CHECK;
          end
          res.valid = 1'b1;
          res.data  = item.data;
        end
        PH_CHECK: begin
          res.valid  = 1'b1;
          res.is_end = 1'b1;
          res.good   = (sum_chk == SUM_GOOD);
          res.len    = exp_len_r;
          phase_nxt  = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      exp_len_r <= '0;
      taken_r   <= '0;
      sum_r     <= '0;
    end else if (take) begin
      phase_r   <= phase_nxt;
      exp_len_r <= exp_len_nxt;
      taken_r   <= taken_nxt;
      sum_r     <= sum_nxt;
    end
  end

  a_byte_in_payload: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res.valid && !res.is_end) |-> (phase_r == PH_PAYLOAD))
    else $error("payload beat outside payload phase");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (take && item.func) |=> (phase_r == PH_LEN_HI && sum_r == '0 && taken_r == '0))
    else $error("start event did not restart reception");

  a_end_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res.valid && res.is_end) |=> (phase_r == PH_IDLE))
    else $error("frame end did not return to idle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAYLOAD) |-> (taken_r < exp_len_r))
    else $error("payload count overran header length");

endmodule
`default_nettype wire

// ----- rtl/core/lcd_out_reg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// lcd_out_reg
// Result register: holds one result beat until the sink takes it.
// ----------------------------------------------------------------------------
module lcd_out_reg
  import lcd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         load,
  input  wire lcd_res_t     res,
  output logic              free,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [23:0]       out_tdata,  // [7:0] out_byte, [23:8] frame_length
  output logic              out_tlast,  // frame_end
  output logic [0:0]        out_tuser   // [0] frame_good
);

  logic     valid_r, valid_nxt;
  lcd_res_t res_r;

  assign free       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.len, res_r.data};
  assign out_tlast  = res_r.is_end;
  assign out_tuser  = res_r.good;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/length_checksum_frame_deframer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// length_checksum_frame_deframer
// Length-prefixed frame deframer with an 8-bit additive checksum.
// ----------------------------------------------------------------------------
// A beat with in_tuser set restarts a frame; the next two data beats give the
// big-endian payload length, payload beats are passed out one for one, and the
// checksum beat yields a closing beat with out_tlast set, out_tuser flagging a
// good sum (payload plus checksum equal to 0xFF) and the length in
// out_tdata[23:8]. Bytes outside a frame produce nothing. One beat is accepted
// every cycle while the output is not stalled; its result passes through the
// input register, then the result register, before it is presented on the
// output. in_tready follows out_tready combinationally when both registers are
// full.
// ----------------------------------------------------------------------------
module length_checksum_frame_deframer
  import lcd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  in_tuser,   // [0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // [7:0] out_byte, [23:8] frame_length
  output logic             out_tlast,  // frame_end
  output logic [0:0]       out_tuser   // [0] frame_good
);

  logic      item_valid;
  lcd_item_t item;
  lcd_res_t  res;
  logic      out_free;
  logic      advance;

  assign advance = item_valid && out_free;

  lcd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  lcd_parse u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (advance),
    .item  (item),
    .res   (res)
  );

  lcd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res.valid),
    .res        (res),
    .free       (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule
`default_nettype wire
